// ===== src/swoc_pkg.sv =====
// ----------------------------------------------------------------------------
// swoc_pkg
// shared types and constants of the sliding window outlier counter
// ----------------------------------------------------------------------------
package swoc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCompareGreater = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStatisticMode  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWindowLength   = 2'd2;

  // statistic modes, the unused code acts as the mean
  localparam logic [1:0] StatMin      = 2'd0;
  localparam logic [1:0] StatMax      = 2'd1;
  localparam logic [1:0] StatMean     = 2'd2;
  localparam logic [1:0] StatReserved = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCheck,
    StCompare,
    StInsert,
    StBackRead,
    StPop,
    StPush
  } state_e;

endpackage

// ===== src/sliding_window_outlier_counter_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_outlier_counter_top
// counts samples above or below the min, max or mean of a time window
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata {sample_value, sample_time}, tuser series_start
//  m_axis    out        tdata hit_total, tuser {window_overflow, hit}
//  cfg       in         cfg_index_i register index, cfg_data_i write data
//
// one item at a time: accept, then a read and a check per evicted entry and
// for the final window check, a compare, an insert, a back read and a pop
// step per deque back probe (each pop plus the probe that stops the walk), a push
// reset is asynchronous, no memory clearing pass is needed
// the result sits in an output register; a stalled result holds the push
// step until m_axis_tready, the next beat is taken in the following cycle
module sliding_window_outlier_counter_top
  import swoc_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,  // sample_time[31:0], sample_value[63:32]
  input  logic                s_axis_tuser,  // series_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // hit_total[31:0]
  output logic [1:0]          m_axis_tuser,  // hit[0], window_overflow[1]
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FW  = AW + 1;
  localparam int unsigned SW  = ValW + FW + 1;  // sum and product width
  localparam int unsigned RingW = TimeW + ValW;
  localparam int unsigned DqW   = AW + ValW;
  localparam logic [FW-1:0] DepthF = FW'(WINDOW_DEPTH);

  // wrap a slot index plus an offset into the ring
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a, input logic [FW-1:0] b);
    logic [FW:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= {1'b0, DepthF}) begin
      s = s - {1'b0, DepthF};
    end
    return s[AW-1:0];
  endfunction

  // configuration
  logic        cmp_gt_q;
  logic [1:0]  mode_q;
  logic [31:0] wlen_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_gt_q <= 1'b1;
      mode_q   <= StatMin;
      wlen_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCompareGreater: cmp_gt_q <= cfg_data_i[0];
        CfgStatisticMode:  mode_q   <= cfg_data_i[1:0];
        CfgWindowLength:   wlen_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state
  state_e state_q, state_d;
  logic [TimeW-1:0]  t_q, t_d;
  logic [ValW-1:0]   v_q, v_d;
  logic [AW-1:0]     head_q, head_d, dqh_q, dqh_d, slot_q, slot_d;
  logic [FW-1:0]     fill_q, fill_d, dqf_q, dqf_d;
  logic signed [SW-1:0] sum_q, sum_d, prod_q, prod_d;
  logic [31:0]       hits_q, hits_d;
  logic              ovf_q, ovf_d;
  logic              hit_q, hit_d;
  logic              ovalid_q, ovalid_d, ohit_q, ohit_d, oovf_q, oovf_d;
  logic [31:0]       ototal_q, ototal_d;

  // memories
  logic             ring_we, ring_re, dq_we, dq_re;
  logic [AW-1:0]    ring_waddr, dq_waddr, dq_raddr;
  logic [RingW-1:0] ring_wdata, ring_rdata;
  logic [DqW-1:0]   dq_wdata, dq_rdata;

  swoc_mem #(.Depth(WINDOW_DEPTH), .Width(RingW), .AddrW(AW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  swoc_mem #(.Depth(WINDOW_DEPTH), .Width(DqW), .AddrW(AW)) u_deque (
    .clk_i   (clk_i),
    .we_i    (dq_we),
    .waddr_i (dq_waddr),
    .wdata_i (dq_wdata),
    .re_i    (dq_re),
    .raddr_i (dq_raddr),
    .rdata_o (dq_rdata)
  );

  logic [TimeW-1:0]     rd_time;
  logic signed [ValW-1:0] rd_val, dq_val, cur_val;
  logic [AW-1:0]        dq_slot;
  logic                 evict, front_match, hit_c, pop_c;

  assign rd_time = ring_rdata[TimeW-1:0];
  assign rd_val  = ring_rdata[RingW-1:TimeW];
  assign dq_val  = dq_rdata[ValW-1:0];
  assign dq_slot = dq_rdata[DqW-1:ValW];
  assign cur_val = v_q;

  // oldest entry is out of window when its time plus the length is below now
  assign evict = (fill_q != '0) &&
                 (({1'b0, rd_time} + {1'b0, wlen_q}) < {1'b0, t_q});
  // deque front refers to the ring slot being dropped
  assign front_match = (dqf_q != '0) && (dq_slot == head_q);

  always_comb begin
    state_d  = state_q;
    t_d      = t_q;
    v_d      = v_q;
    head_d   = head_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    prod_d   = prod_q;
    dqh_d    = dqh_q;
    dqf_d    = dqf_q;
    slot_d   = slot_q;
    hits_d   = hits_q;
    ovf_d    = ovf_q;
    hit_d    = hit_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ohit_d   = ohit_q;
    oovf_d   = oovf_q;
    ototal_d = ototal_q;
    s_axis_tready = 1'b0;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    ring_waddr = slot_add(head_q, fill_q);
    ring_wdata = {v_q, t_q};
    dq_we      = 1'b0;
    dq_re      = 1'b0;
    dq_raddr   = dqh_q;
    dq_waddr   = slot_add(dqh_q, dqf_q);
    dq_wdata   = {slot_q, v_q};
    hit_c      = 1'b0;
    pop_c      = 1'b0;

    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          t_d = s_axis_tdata[TimeW-1:0];
          v_d = s_axis_tdata[63:TimeW];
          if (s_axis_tuser) begin
            head_d = '0;
            fill_d = '0;
            sum_d  = '0;
            dqh_d  = '0;
            dqf_d  = '0;
            hits_d = '0;
            ovf_d  = 1'b0;
          end
          state_d = StRead;
        end
      end
      StRead: begin
        // fetch oldest ring entry and deque front
        ring_re = 1'b1;
        dq_re   = 1'b1;
        state_d = StCheck;
      end
      StCheck: begin
        if (evict) begin
          if (front_match) begin
            dqh_d = slot_add(dqh_q, FW'(1));
            dqf_d = dqf_q - FW'(1);
          end
          sum_d   = sum_q - SW'(rd_val);
          head_d  = slot_add(head_q, FW'(1));
          fill_d  = fill_q - FW'(1);
          state_d = StRead;
        end else begin
          prod_d  = SW'(cur_val) * $signed({1'b0, fill_q});
          state_d = StCompare;
        end
      end
      StCompare: begin
        if (fill_q != '0) begin
          if (mode_q == StatMin || mode_q == StatMax) begin
            if (dqf_q != '0) begin
              hit_c = cmp_gt_q ? (cur_val > dq_val) : (cur_val < dq_val);
            end
          end else begin
            hit_c = cmp_gt_q ? (prod_q > sum_q) : (prod_q < sum_q);
          end
        end
        // kept apart from the output register, which may still hold a beat
        hit_d = hit_c;
        if (hit_c && hits_q != '1) begin
          hits_d = hits_q + 32'd1;
        end
        // ring full: drop the oldest entry still held in the read registers
        if (fill_q == DepthF) begin
          if (front_match) begin
            dqh_d = slot_add(dqh_q, FW'(1));
            dqf_d = dqf_q - FW'(1);
          end
          sum_d  = sum_q - SW'(rd_val);
          head_d = slot_add(head_q, FW'(1));
          fill_d = fill_q - FW'(1);
          ovf_d  = 1'b1;
        end
        state_d = StInsert;
      end
      StInsert: begin
        ring_we = 1'b1;
        slot_d  = ring_waddr;
        fill_d  = fill_q + FW'(1);
        sum_d   = sum_q + SW'(cur_val);
        state_d = (dqf_q != '0) ? StBackRead : StPush;
      end
      StBackRead: begin
        dq_re    = 1'b1;
        dq_raddr = slot_add(dqh_q, dqf_q - FW'(1));
        state_d  = StPop;
      end
      StPop: begin
        pop_c = (mode_q == StatMax) ? (dq_val <= cur_val) : (dq_val >= cur_val);
        if (pop_c) begin
          dqf_d   = dqf_q - FW'(1);
          state_d = (dqf_q == FW'(1)) ? StPush : StBackRead;
        end else begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (!ovalid_q || m_axis_tready) begin
          dq_we    = 1'b1;
          dqf_d    = dqf_q + FW'(1);
          ovalid_d = 1'b1;
          ohit_d   = hit_q;
          ototal_d = hits_q;
          oovf_d   = ovf_q;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      head_q   <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
      dqh_q    <= '0;
      dqf_q    <= '0;
      hits_q   <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      dqh_q    <= dqh_d;
      dqf_q    <= dqf_d;
      hits_q   <= hits_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    v_q      <= v_d;
    prod_q   <= prod_d;
    slot_q   <= slot_d;
    hit_q    <= hit_d;
    ohit_q   <= ohit_d;
    oovf_q   <= oovf_d;
    ototal_q <= ototal_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = ototal_q;
  assign m_axis_tuser  = {oovf_q, ohit_q};

endmodule

// ===== src/swoc_mem.sv =====
// ----------------------------------------------------------------------------
// swoc_mem
// simple dual port synchronous memory, one write and one registered read
// ----------------------------------------------------------------------------
module swoc_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 64,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/swoc_checker.sv =====
// ----------------------------------------------------------------------------
// swoc_checker
// port level checks of the sliding window outlier counter
// ----------------------------------------------------------------------------
module swoc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // a hit always shows a nonzero running count
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != 32'd0)
    else $error("hit with zero count");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // a result never rises straight from the idle state
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared from idle");

endmodule

bind sliding_window_outlier_counter_top swoc_checker u_swoc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the sliding window outlier counter against a cycle-free predictor
// of the windowed min, max and mean comparison, with random stalls on both
// stream sides and register changes between phases
// ----------------------------------------------------------------------------
module testbench;
  import swoc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 1024;
  localparam int unsigned StallLimit = 200000;

  typedef struct packed {
    logic        hit;
    logic [31:0] total;
    logic        ovf;
  } outcome_t;

  // window predictor plus queue of expected outcomes
  class outlier_scoreboard;
    logic [31:0] ring_t [Depth];
    logic [31:0] ring_v [Depth];
    int unsigned mono_slot [Depth];
    logic [31:0] mono_val [Depth];
    int unsigned head, fill, mhead, mfill;
    longint      sum;
    logic [31:0] hits;
    logic        ovf;
    logic        greater;
    logic [1:0]  mode;
    logic [31:0] span;
    outcome_t    pending[$];
    int          errors;
    int          checked;

    function new();
      greater = 1'b1;
      mode = StatMin;
      span = '0;
      clear();
    endfunction

    function void clear();
      head = 0; fill = 0; mhead = 0; mfill = 0; sum = 0; hits = '0; ovf = 1'b0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        CfgCompareGreater: greater = data[0];
        CfgStatisticMode: mode = data[1:0];
        CfgWindowLength: span = data;
        default: ;
      endcase
    endfunction

    function void drop_oldest();
      if (mfill != 0 && mono_slot[mhead] == head) begin
        mhead = (mhead + 1) % Depth;
        mfill--;
      end
      sum -= longint'($signed(ring_v[head]));
      head = (head + 1) % Depth;
      fill--;
    endfunction

    function void note_sample(logic [31:0] t, logic [31:0] vb, logic start);
      longint v, stat, lhs;
      logic hit;
      logic use_max;
      int unsigned slot, back;
      outcome_t o;
      v = longint'($signed(vb));
      use_max = (mode == StatMax);
      hit = 1'b0;
      if (start) clear();
      while (fill != 0 && ({1'b0, ring_t[head]} + {1'b0, span}) < {1'b0, t})
        drop_oldest();
      if (fill != 0) begin
        if (mode <= StatMax) begin
          if (mfill != 0) begin
            stat = longint'($signed(mono_val[mhead]));
            hit = greater ? (v > stat) : (v < stat);
          end
        end else begin
          lhs = v * longint'(fill);
          hit = greater ? (lhs > sum) : (lhs < sum);
        end
      end
      if (hit && hits != 32'hFFFF_FFFF) hits++;
      if (fill == Depth) begin
        drop_oldest();
        ovf = 1'b1;
      end
      slot = (head + fill) % Depth;
      ring_t[slot] = t;
      ring_v[slot] = vb;
      fill++;
      sum += v;
      while (mfill != 0) begin
        back = (mhead + mfill - 1) % Depth;
        stat = longint'($signed(mono_val[back]));
        if (use_max ? (stat <= v) : (stat >= v)) mfill--;
        else break;
      end
      mono_slot[(mhead + mfill) % Depth] = slot;
      mono_val[(mhead + mfill) % Depth] = vb;
      mfill++;
      o.hit = hit; o.total = hits; o.ovf = ovf;
      pending = {pending, o};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] total, logic [1:0] flags);
      outcome_t o;
      if (pending.size() == 0) begin
        $display("unexpected result beat, total %0h", total);
        errors++;
        return;
      end
      o = pending.pop_front();
      if (flags[0] !== o.hit) report("hit", flags[0], o.hit);
      if (total !== o.total) report("hit_total", total, o.total);
      if (flags[1] !== o.ovf) report("window_overflow", flags[1], o.ovf);
      checked++;
    endtask
  endclass

  logic              clk_i, rst_ni;
  logic              s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [63:0]       s_axis_tdata;
  logic              m_axis_tvalid, m_axis_tready;
  logic [31:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]       cfg_data_i;

  outlier_scoreboard sb;
  int unsigned idle_cycles;
  bit          sending;
  int unsigned samples_sent;
  logic [31:0] clock_now;

  sliding_window_outlier_counter_top #(.WINDOW_DEPTH(Depth)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // half the time no gap, else mostly short, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random back-pressure, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int unsigned g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (sending && g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("[sliding_window_outlier_counter_top] ERROR");
      $finish;
    end
  end

  task automatic send_sample(logic [31:0] t, logic [31:0] v, logic start);
    int unsigned g;
    g = gap_len();
    // step off the edge where the previous beat was released
    repeat (g + 1) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v, t};
    s_axis_tuser <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(t, v, start);
    samples_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_all(logic g, logic [1:0] m, logic [31:0] w);
    drain();
    write_reg(CfgCompareGreater, {31'd0, g});
    write_reg(CfgStatisticMode, {30'd0, m});
    write_reg(CfgWindowLength, w);
  endtask

  // random value: extremes, small spread or full range
  function automatic logic [31:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (r < 6) return $urandom_range(0, 40) - 20;
    return $urandom();
  endfunction

  // one series with non-decreasing times, occasional step back
  task automatic random_series(int unsigned n, int unsigned step_max);
    logic [31:0] step;
    for (int unsigned i = 0; i < n; i++) begin
      step = $urandom_range(0, step_max);
      if ($urandom_range(0, 30) == 0) clock_now = clock_now - $urandom_range(0, 10);
      else if (clock_now > 32'hFFFF_FFFF - step) clock_now = 32'hFFFF_FFFF;
      else clock_now = clock_now + step;
      send_sample(clock_now, rand_value(), i == 0);
    end
  endtask

  initial begin
    sb = new();
    sending = 1'b0;
    samples_sent = 0;
    idle_cycles = 0;
    clock_now = '0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgCompareGreater;
    cfg_data_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    sending = 1'b1;

    // directed: reset settings, empty window on first sample, extremes
    send_sample(32'd0, 32'd5, 1'b1);
    send_sample(32'd0, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'd0, 32'h8000_0000, 1'b0);
    send_sample(32'd1, 32'd3, 1'b0);
    set_all(1'b0, StatMax, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFF0, 32'd1, 1'b1);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    send_sample(32'h0000_0010, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'd0, 1'b0);
    set_all(1'b1, StatMean, 32'd10);
    send_sample(32'd100, 32'h7FFF_FFFF, 1'b1);
    send_sample(32'd105, 32'h7FFF_FFFF, 1'b0);
    send_sample(32'd110, 32'h8000_0000, 1'b0);
    send_sample(32'd103, 32'd0, 1'b0);
    send_sample(32'd200, 32'd4, 1'b0);
    set_all(1'b0, StatReserved, 32'd10);
    send_sample(32'd0, 32'd7, 1'b1);
    send_sample(32'd2, 32'd1, 1'b0);
    send_sample(32'd4, 32'd9, 1'b0);
    // mode change inside a series, once the block is idle
    drain();
    write_reg(CfgStatisticMode, {30'd0, StatMin});
    send_sample(32'd5, 32'd2, 1'b0);

    // sender waits for the block to empty completely
    drain();

    // ring overflow: one long series in a huge window, then counter growth
    set_all(1'b1, StatMin, 32'hFFFF_FFFF);
    clock_now = '0;
    random_series(1060, 2);

    // random phases over register settings
    while (samples_sent < 1400) begin
      set_all(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
              ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 64));
      clock_now = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FF00 : $urandom_range(0, 1000);
      repeat ($urandom_range(1, 4)) random_series($urandom_range(1, 60), 8);
    end

    drain();
    sending = 1'b0;
    $display("run covered %0d samples and %0d checked results", samples_sent, sb.checked);
    $display("all statistic modes, both comparisons, wrap, overflow and mode changes used");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[sliding_window_outlier_counter_top] OK");
    end else begin
      $display("[sliding_window_outlier_counter_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sliding_window_outlier_counter_top.f =====
src/swoc_pkg.sv
src/swoc_mem.sv
src/sliding_window_outlier_counter_top.sv
src/swoc_checker.sv
dv/testbench.sv
